/* design/mqsb_pkg.sv */
package mqsb_pkg;

  // sizes
  localparam int NUM_QUEUES = 4;
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  // field widths
  localparam int CMD_W   = 1;
  localparam int QID_W   = 2;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;

  // entry index and link widths, a link can also hold the null code
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PTR_W = $clog2(DEPTH + 1);

  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(DEPTH);

  // operation codes
  localparam logic [CMD_W-1:0] CMD_ENQ = 1'b0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic issue;   // word taken, memory reads and early writes
    logic commit;  // pointer update and result load
  } cmd_t;

  // a link at or above the depth counts as null
  function automatic logic is_null(ptr_t p);
    return p >= NULL_PTR;
  endfunction

endpackage

/* design/mqsb_if.sv */
// request channel
interface mqsb_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [mqsb_pkg::CMD_W-1:0]           command;
  logic [mqsb_pkg::QID_W-1:0]           queue_id;
  logic signed [mqsb_pkg::VALUE_W-1:0]  write_value;

  modport source (output valid, command, queue_id, write_value, input ready);
  modport sink   (input valid, command, queue_id, write_value, output ready);
endinterface

// response channel
interface mqsb_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mqsb_pkg::VALUE_W-1:0]  read_value;
  logic [mqsb_pkg::STAT_W-1:0]          status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

/* design/mqsb_ctrl.sv */
module mqsb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mqsb_pkg::cmd_t cmd_o
);

  mqsb_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  // state and result flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mqsb_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.issue   = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      mqsb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.issue = 1'b1;
          state_d     = mqsb_pkg::ST_EXEC;
        end
      end
      mqsb_pkg::ST_EXEC: begin
        // hold until the output register has room
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = mqsb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mqsb_pkg::ST_IDLE;
      end
    endcase
  end

  // result word flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  a_issue_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |=> state_q == mqsb_pkg::ST_EXEC)
    else $error("issue not followed by exec");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.issue && cmd_o.commit))
    else $error("issue and commit together");

  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.commit))
    else $error("result flag rose without commit");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mqsb_pkg::ST_EXEC && out_valid_q && !out_ready_i)
      |=> state_q == mqsb_pkg::ST_EXEC)
    else $error("exec left while output blocked");

endmodule

/* design/mqsb_dp.sv */
module mqsb_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mqsb_pkg::cmd_t                      cmd_i,
  input  logic [mqsb_pkg::CMD_W-1:0]          command_i,
  input  logic [mqsb_pkg::QID_W-1:0]          queue_id_i,
  input  logic signed [mqsb_pkg::VALUE_W-1:0] write_value_i,
  output logic signed [mqsb_pkg::VALUE_W-1:0] read_value_o,
  output logic [mqsb_pkg::STAT_W-1:0]         status_o
);

  // queue pointers and free list head
  mqsb_pkg::ptr_t head_q [mqsb_pkg::NUM_QUEUES];
  mqsb_pkg::ptr_t tail_q [mqsb_pkg::NUM_QUEUES];
  mqsb_pkg::ptr_t free_head_q;

  // link memory, valid bits stand for the reset chain
  mqsb_pkg::ptr_t link_mem_q [mqsb_pkg::DEPTH];
  logic [mqsb_pkg::DEPTH-1:0] link_vld_q;
  mqsb_pkg::ptr_t link_rd_q;
  logic           link_rd_vld_q;
  mqsb_pkg::idx_t link_rd_idx_q;

  // data memory
  mqsb_pkg::data_t data_mem_q [mqsb_pkg::DEPTH];
  mqsb_pkg::data_t data_rd_q;

  // operation held between issue and commit
  logic [mqsb_pkg::CMD_W-1:0] cmd_q;
  logic [mqsb_pkg::QID_W-1:0] qid_q;
  mqsb_pkg::ptr_t             entry_q;
  logic                       ok_q;
  logic                       head_null_q;

  // result register
  logic signed [mqsb_pkg::VALUE_W-1:0] read_value_q;
  logic [mqsb_pkg::STAT_W-1:0]         status_q;

  // issue-time decode
  logic           qid_ok;
  mqsb_pkg::ptr_t head_sel;
  mqsb_pkg::ptr_t tail_sel;
  logic           enq_ok;
  logic           deq_ok;
  mqsb_pkg::ptr_t entry_sel;
  logic           tail_link_we;

  // commit-time values
  mqsb_pkg::ptr_t next_link;

  // link write port
  logic           link_we;
  mqsb_pkg::idx_t link_waddr;
  mqsb_pkg::ptr_t link_wdata;

  always_comb begin
    qid_ok    = 32'(queue_id_i) < mqsb_pkg::NUM_QUEUES;
    head_sel  = head_q[queue_id_i];
    tail_sel  = tail_q[queue_id_i];
    enq_ok    = (command_i == mqsb_pkg::CMD_ENQ) && qid_ok &&
                !mqsb_pkg::is_null(free_head_q);
    deq_ok    = (command_i == mqsb_pkg::CMD_DEQ) && qid_ok &&
                !mqsb_pkg::is_null(head_sel);
    entry_sel = (command_i == mqsb_pkg::CMD_ENQ) ? free_head_q : head_sel;
    // chain the new entry behind a non-empty queue's tail
    tail_link_we = enq_ok && !mqsb_pkg::is_null(head_sel) &&
                   !mqsb_pkg::is_null(tail_sel);
  end

  // link read data, an unwritten entry still points to the next one
  assign next_link = link_rd_vld_q ? link_rd_q
                                   : mqsb_pkg::PTR_W'(link_rd_idx_q) + 1'b1;

  // one link write per cycle: tail link at issue, entry link at commit
  always_comb begin
    link_we    = 1'b0;
    link_waddr = entry_q[mqsb_pkg::IDX_W-1:0];
    link_wdata = mqsb_pkg::NULL_PTR;
    if (cmd_i.issue) begin
      link_we    = tail_link_we;
      link_waddr = tail_sel[mqsb_pkg::IDX_W-1:0];
      link_wdata = free_head_q;
    end else if (cmd_i.commit && ok_q) begin
      link_we    = 1'b1;
      link_waddr = entry_q[mqsb_pkg::IDX_W-1:0];
      link_wdata = (cmd_q == mqsb_pkg::CMD_ENQ) ? mqsb_pkg::NULL_PTR : free_head_q;
    end
  end

  // link memory
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem_q[link_waddr] <= link_wdata;
    end
    if (cmd_i.issue) begin
      link_rd_q     <= link_mem_q[entry_sel[mqsb_pkg::IDX_W-1:0]];
      link_rd_idx_q <= entry_sel[mqsb_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q    <= '0;
      link_rd_vld_q <= 1'b0;
    end else begin
      if (link_we) begin
        link_vld_q[link_waddr] <= 1'b1;
      end
      if (cmd_i.issue) begin
        link_rd_vld_q <= link_vld_q[entry_sel[mqsb_pkg::IDX_W-1:0]];
      end
    end
  end

  // data memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue && enq_ok) begin
      data_mem_q[free_head_q[mqsb_pkg::IDX_W-1:0]] <=
        mqsb_pkg::DATA_WIDTH'(write_value_i);
    end
    if (cmd_i.issue) begin
      data_rd_q <= data_mem_q[head_sel[mqsb_pkg::IDX_W-1:0]];
    end
  end

  // operation latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      cmd_q       <= command_i;
      qid_q       <= queue_id_i;
      entry_q     <= entry_sel;
      ok_q        <= enq_ok || deq_ok;
      head_null_q <= mqsb_pkg::is_null(head_sel);
    end
  end

  // pointer updates at commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      for (int i = 0; i < mqsb_pkg::NUM_QUEUES; i++) begin
        head_q[i] <= mqsb_pkg::NULL_PTR;
      end
    end else if (cmd_i.commit && ok_q) begin
      if (cmd_q == mqsb_pkg::CMD_ENQ) begin
        free_head_q <= next_link;
        if (head_null_q) begin
          head_q[qid_q] <= entry_q;
        end
      end else begin
        head_q[qid_q] <= next_link;
        free_head_q   <= entry_q;
      end
    end
  end

  // tail pointers need no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && ok_q && (cmd_q == mqsb_pkg::CMD_ENQ)) begin
      tail_q[qid_q] <= entry_q;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (ok_q) begin
        status_q <= mqsb_pkg::STAT_OK;
      end else if (cmd_q == mqsb_pkg::CMD_ENQ) begin
        status_q <= mqsb_pkg::STAT_FULL;
      end else begin
        status_q <= mqsb_pkg::STAT_EMPTY;
      end
      if (ok_q && (cmd_q == mqsb_pkg::CMD_DEQ)) begin
        read_value_q <= mqsb_pkg::VALUE_W'(data_rd_q);
      end else begin
        read_value_q <= '0;
      end
    end
  end

  assign read_value_o = read_value_q;
  assign status_o     = status_q;

endmodule

/* design/multi_queue_shared_buffer_top.sv */
// Four FIFO queues share one 16-entry store of 32-bit words, chained by a
// link memory with a free list of unused entries, so any mix of queue
// lengths up to 16 words in total fits. Each request word is an enqueue or
// a dequeue on one queue and yields exactly one response word: status ok,
// full (free list empty) or empty (queue has no words), with the dequeued
// value on a good dequeue and zero otherwise. A request has an issue step,
// for the registered reads of the link and data memories and for the tail
// link write, and then a commit step, for the pointer update and the
// response load; the request side is ready again as soon as the response
// sits in the output register, and only a response that is still not taken
// when the next request is due to commit holds that request back.
module multi_queue_shared_buffer_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  mqsb_in_if.sink           in_i,
  mqsb_out_if.source        out_o
);

  mqsb_pkg::cmd_t cmd;

  // sequencing
  mqsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // pointers, memories and result register
  mqsb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .command_i     (in_i.command),
    .queue_id_i    (in_i.queue_id),
    .write_value_i (in_i.write_value),
    .read_value_o  (out_o.read_value),
    .status_o      (out_o.status)
  );

endmodule

/* test/multi_queue_shared_buffer_top_tb.sv */
`timescale 1ns / 100ps

module multi_queue_shared_buffer_top_tb;

  typedef logic signed [mqsb_pkg::VALUE_W-1:0] word_t;

  typedef struct packed {
    word_t                       read_value;
    logic [mqsb_pkg::STAT_W-1:0] status;
  } response_t;

  typedef struct packed {
    logic [mqsb_pkg::CMD_W-1:0]  command;
    logic [mqsb_pkg::QID_W-1:0]  queue_id;
    word_t                       write_value;
    logic                        fixed;
    response_t                   want;
  } stim_row_t;

  // idle patterns for either side of the block
  typedef enum int {
    PACE_STEADY,
    PACE_SHORT,
    PACE_BURSTY
  } pace_e;

  // mix of enqueues and dequeues in a random phase
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_e;

  localparam int RANDOM_WORDS = 900;
  localparam int HOLD_CYCLES  = 80;
  localparam int HOLD_EVERY   = 300;
  localparam int PHASE_WORDS  = 40;
  localparam int DRAIN_CYCLES = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mqsb_in_if  in_if ();
  mqsb_out_if out_if ();

  multi_queue_shared_buffer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the linked store
  mqsb_pkg::data_t slot_value [mqsb_pkg::DEPTH];
  mqsb_pkg::ptr_t  slot_link  [mqsb_pkg::DEPTH];
  mqsb_pkg::ptr_t  queue_head [mqsb_pkg::NUM_QUEUES];
  mqsb_pkg::ptr_t  queue_tail [mqsb_pkg::NUM_QUEUES];
  mqsb_pkg::ptr_t  free_head;

  response_t expected_responses [$];
  int        error_count    = 0;
  int        responses_seen = 0;
  pace_e     tx_pace        = PACE_STEADY;

  // typed expectation travelling with the word on the request channel
  logic      row_fixed;
  response_t row_want;

  function automatic void clear_shadow();
    for (int i = 0; i < mqsb_pkg::DEPTH; i++) begin
      slot_value[i] = '0;
      slot_link[i]  = mqsb_pkg::ptr_t'(i + 1);
    end
    for (int q = 0; q < mqsb_pkg::NUM_QUEUES; q++) begin
      queue_head[q] = mqsb_pkg::NULL_PTR;
      queue_tail[q] = mqsb_pkg::NULL_PTR;
    end
    free_head = '0;
  endfunction

  // one enqueue or dequeue on the shadow store, returns the response word
  function automatic response_t apply_queue_op(logic [mqsb_pkg::CMD_W-1:0] cmd,
                                                logic [mqsb_pkg::QID_W-1:0] qid,
                                                word_t value);
    response_t      rsp;
    mqsb_pkg::ptr_t slot;
    mqsb_pkg::idx_t idx;
    int             q;
    rsp.read_value = '0;
    rsp.status     = mqsb_pkg::STAT_OK;
    q = int'(qid);
    if (cmd == mqsb_pkg::CMD_ENQ) begin
      if (q >= mqsb_pkg::NUM_QUEUES || free_head >= mqsb_pkg::NULL_PTR) begin
        rsp.status = mqsb_pkg::STAT_FULL;
      end else begin
        slot      = free_head;
        idx       = slot[mqsb_pkg::IDX_W-1:0];
        free_head = slot_link[idx];
        // first word of an empty queue becomes its head, else chain after tail
        if (queue_head[q] >= mqsb_pkg::NULL_PTR) begin
          queue_head[q] = slot;
        end else if (queue_tail[q] < mqsb_pkg::NULL_PTR) begin
          slot_link[queue_tail[q][mqsb_pkg::IDX_W-1:0]] = slot;
        end
        slot_link[idx]  = mqsb_pkg::NULL_PTR;
        queue_tail[q]   = slot;
        slot_value[idx] = mqsb_pkg::data_t'(value);
      end
    end else begin
      if (q >= mqsb_pkg::NUM_QUEUES || queue_head[q] >= mqsb_pkg::NULL_PTR) begin
        rsp.status = mqsb_pkg::STAT_EMPTY;
      end else begin
        slot          = queue_head[q];
        idx           = slot[mqsb_pkg::IDX_W-1:0];
        queue_head[q] = slot_link[idx];
        // freed entry goes back on top of the free list
        slot_link[idx] = free_head;
        free_head      = slot;
        rsp.read_value = word_t'(slot_value[idx]);
      end
    end
    return rsp;
  endfunction

  function automatic stim_row_t make_row(logic [mqsb_pkg::CMD_W-1:0] cmd,
                                         logic [mqsb_pkg::QID_W-1:0] qid,
                                         word_t value, logic fixed, word_t want_value,
                                         logic [mqsb_pkg::STAT_W-1:0] want_status);
    stim_row_t row;
    row.command         = cmd;
    row.queue_id        = qid;
    row.write_value     = value;
    row.fixed           = fixed;
    row.want.read_value = want_value;
    row.want.status     = want_status;
    return row;
  endfunction

  function automatic word_t pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return word_t'($urandom());
    endcase
  endfunction

  // idle length in cycles, mostly short and now and then long
  function automatic int pick_gap(pace_e pace);
    case (pace)
      PACE_STEADY: return 0;
      PACE_SHORT:  return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      default: begin
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 30);
        return ($urandom_range(0, 1) == 0) ? $urandom_range(1, 2) : 0;
      end
    endcase
  endfunction

  // offer one word and wait until it is taken
  task automatic send_word(stim_row_t row);
    int gap;
    gap = pick_gap(tx_pace);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= row.command;
    in_if.queue_id    <= row.queue_id;
    in_if.write_value <= row.write_value;
    row_fixed         <= row.fixed;
    row_want          <= row.want;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // response check first, then the prediction for a word taken at this edge
  always @(posedge clk_i) begin
    response_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      responses_seen++;
      if (expected_responses.size() == 0) begin
        $display("%0t: unexpected response, read_value %0d status %0d",
                 $time, out_if.read_value, out_if.status);
        error_count++;
      end else begin
        want = expected_responses.pop_front();
        if (out_if.read_value !== want.read_value) begin
          $display("%0t: read_value expected %0d actual %0d",
                   $time, want.read_value, out_if.read_value);
          error_count++;
        end
        if (out_if.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, out_if.status);
          error_count++;
        end
      end
    end
    if (rst_ni && in_if.valid && in_if.ready) begin
      want = apply_queue_op(in_if.command, in_if.queue_id, in_if.write_value);
      expected_responses.push_back(row_fixed ? row_want : want);
    end
  end

  // response side: random stalls plus a few long hold-offs to back up the block
  initial begin
    int    stall_left;
    int    next_hold;
    int    cycle_count;
    pace_e rx_pace;
    out_if.ready <= 1'b0;
    stall_left  = 0;
    next_hold   = HOLD_EVERY / 2;
    cycle_count = 0;
    rx_pace     = PACE_STEADY;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count % 64 == 0) rx_pace = pace_e'($urandom_range(0, 2));
      if (responses_seen >= next_hold) begin
        stall_left = HOLD_CYCLES;
        next_hold  = next_hold + HOLD_EVERY;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = pick_gap(rx_pace);
      end
    end
  end

  // request side: directed rows, then random phases
  initial begin
    stim_row_t                  rows [$];
    mix_e                       mix;
    int                         focus;
    int                         enq_pct;
    int                         words_sent;
    logic [mqsb_pkg::CMD_W-1:0] cmd;
    logic [mqsb_pkg::QID_W-1:0] qid;
    in_if.valid       <= 1'b0;
    in_if.command     <= mqsb_pkg::CMD_ENQ;
    in_if.queue_id    <= '0;
    in_if.write_value <= '0;
    row_fixed         <= 1'b0;
    row_want          <= '0;
    clear_shadow();
    mix        = MIX_EVEN;
    focus      = -1;
    words_sent = 0;

    // every queue empty after reset
    for (int q = 0; q < mqsb_pkg::NUM_QUEUES; q++) begin
      rows.push_back(make_row(mqsb_pkg::CMD_DEQ, mqsb_pkg::QID_W'(q), '1, 1'b1, '0,
                              mqsb_pkg::STAT_EMPTY));
    end
    // value extremes through the lowest and highest queue
    rows.push_back(make_row(mqsb_pkg::CMD_ENQ, '0, 32'sh8000_0000, 1'b1, '0,
                            mqsb_pkg::STAT_OK));
    rows.push_back(make_row(mqsb_pkg::CMD_ENQ, '1, 32'sh7fff_ffff, 1'b1, '0,
                            mqsb_pkg::STAT_OK));
    rows.push_back(make_row(mqsb_pkg::CMD_DEQ, '0, '0, 1'b1, 32'sh8000_0000,
                            mqsb_pkg::STAT_OK));
    rows.push_back(make_row(mqsb_pkg::CMD_DEQ, '1, '0, 1'b1, 32'sh7fff_ffff,
                            mqsb_pkg::STAT_OK));
    rows.push_back(make_row(mqsb_pkg::CMD_DEQ, '1, '0, 1'b1, '0, mqsb_pkg::STAT_EMPTY));
    // use up every entry across all queues, then one more is full
    for (int i = 0; i < mqsb_pkg::DEPTH; i++) begin
      rows.push_back(make_row(mqsb_pkg::CMD_ENQ,
                              mqsb_pkg::QID_W'(i % mqsb_pkg::NUM_QUEUES), pick_value(),
                              1'b0, '0, mqsb_pkg::STAT_OK));
    end
    rows.push_back(make_row(mqsb_pkg::CMD_ENQ, mqsb_pkg::QID_W'(1), 32'sh1234_5678, 1'b1,
                            '0, mqsb_pkg::STAT_FULL));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_word(rows[i]);
      words_sent++;
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // new phase: fill, drain or even mix, sometimes all on one queue
      if (n % PHASE_WORDS == 0) begin
        mix     = mix_e'($urandom_range(0, 2));
        focus   = ($urandom_range(0, 2) == 0) ?
                  $urandom_range(0, mqsb_pkg::NUM_QUEUES - 1) : -1;
        tx_pace = pace_e'($urandom_range(0, 2));
      end
      case (mix)
        MIX_FILL:  enq_pct = 85;
        MIX_DRAIN: enq_pct = 15;
        default:   enq_pct = 50;
      endcase
      cmd = ($urandom_range(0, 99) < enq_pct) ? mqsb_pkg::CMD_ENQ : mqsb_pkg::CMD_DEQ;
      qid = (focus < 0) ? mqsb_pkg::QID_W'($urandom_range(0, mqsb_pkg::NUM_QUEUES - 1))
                        : mqsb_pkg::QID_W'(focus);
      send_word(make_row(cmd, qid, pick_value(), 1'b0, '0, mqsb_pkg::STAT_OK));
      words_sent++;
    end
    in_if.valid <= 1'b0;

    // wait for one response per word sent
    while (responses_seen < words_sent) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_responses.size() == 0) begin
      $display("multi_queue_shared_buffer_top test passed");
    end else begin
      $display("multi_queue_shared_buffer_top test failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("multi_queue_shared_buffer_top test failed");
    $finish;
  end

endmodule
